>>> sv/srt_pkg.sv
`timescale 1ns / 1ps
// Package for the ascending value sorter: capacity, widths and shared types.
// No dependencies; used by srt_cell, sort_values_ascending and the testbench.
package srt_pkg;

   localparam int MaxItems   = 64;
   localparam int ValueWidth = 32;
   localparam int CountWidth = $clog2(MaxItems + 1);

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic [CountWidth-1:0]        count_type;

   // Shared command to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

   typedef enum logic {
      StIdle,
      StDrain
   } state_type;

endpackage

>>> sv/srt_cell.sv
`timescale 1ns / 1ps
// One cell of the sorting chain: holds a single stored value.
// Depends on srt_pkg for the value and control types.
module srt_cell (
   input  logic                   clock,
   input  srt_pkg::cell_ctrl_type ctrl,
   input  srt_pkg::value_type     new_value,
   input  logic                   occupied,
   input  srt_pkg::value_type     left_value,
   input  logic                   left_greater,
   input  srt_pkg::value_type     right_value,
   output srt_pkg::value_type     value,
   output logic                   greater
);

   srt_pkg::value_type value_ff;
   srt_pkg::value_type value_in;

   // An empty cell counts as larger than any value, so new values land there.
   assign greater = !occupied || (value_ff > new_value);
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.drain) begin
         value_in = right_value;
      end else if (ctrl.insert && greater) begin
         // The first greater cell takes the new value; the ones after it shift up.
         value_in = left_greater ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

>>> sv/sort_values_ascending.sv
`timescale 1ns / 1ps
// Top level of the ascending value sorter: control and the chain of cells.
// Depends on srt_pkg and srt_cell.
//
//   channel  ports                                     handshake
//   input    req_value, req_last                       start && !busy
//   result   rsp_sorted_value, rsp_end_of_set          rsp_valid, one cycle each
//
// An item is inserted at its ordered place in the cycle it is accepted;
// one that arrives while the chain is full is dropped. An item with req_last set
// starts a drain of all stored values, one result per cycle from the head of the
// chain; busy stays high meanwhile.
// Synchronous reset empties the set; the receiver cannot stall results.
module sort_values_ascending (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [31:0]        req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   output logic signed [31:0]        rsp_sorted_value,
   output logic                      rsp_end_of_set
);

   localparam int N = srt_pkg::MaxItems;

   srt_pkg::state_type     state_ff;
   srt_pkg::state_type     state_in;
   srt_pkg::count_type     count_ff;
   srt_pkg::count_type     count_in;
   srt_pkg::cell_ctrl_type ctrl;
   logic                   accept;
   logic                   has_room;

   srt_pkg::value_type cell_value   [N];
   logic               cell_greater [N];

   assign accept   = start && (state_ff == srt_pkg::StIdle);
   assign has_room = count_ff < srt_pkg::count_type'(N);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ctrl.insert = 1'b0;
      ctrl.drain  = 1'b0;
      case (state_ff)
         srt_pkg::StIdle: begin
            if (accept) begin
               ctrl.insert = has_room;
               if (has_room) begin
                  count_in = count_ff + srt_pkg::count_type'(1);
               end
               if (req_last) begin
                  state_in = srt_pkg::StDrain;
               end
            end
         end
         srt_pkg::StDrain: begin
            ctrl.drain = 1'b1;
            count_in   = count_ff - srt_pkg::count_type'(1);
            if (count_ff == srt_pkg::count_type'(1)) begin
               state_in = srt_pkg::StIdle;
            end
         end
         default: begin
            state_in = srt_pkg::StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         srt_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .new_value    (req_value),
            .occupied     (srt_pkg::count_type'(i) < count_ff),
            .left_value   (cell_value[(i == 0) ? 0 : i - 1]),
            .left_greater ((i == 0) ? 1'b0 : cell_greater[(i == 0) ? 0 : i - 1]),
            .right_value  (cell_value[(i == N - 1) ? i : i + 1]),
            .value        (cell_value[i]),
            .greater      (cell_greater[i])
         );
      end
   endgenerate

   assign busy             = (state_ff == srt_pkg::StDrain);
   assign rsp_valid        = (state_ff == srt_pkg::StDrain);
   assign rsp_sorted_value = cell_value[0];
   assign rsp_end_of_set   = rsp_valid && (count_ff == srt_pkg::count_type'(1));

endmodule

>>> sv/srt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ascending value sorter, bound to the top level.
// Depends only on the ports of sort_values_ascending.
module srt_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_last,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_sorted_value,
   input logic               rsp_end_of_set
);

   // A final item starts the output of its set in the next cycle.
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last) |=> rsp_valid)
      else $error("final item did not start the result stream");

   // Results form one unbroken burst that ends on the flagged one.
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_end_of_set) |=> rsp_valid)
      else $error("result stream broke before the end of the set");

   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_set) |=> !rsp_valid)
      else $error("result after the end of the set");

   // Results within a set never decrease.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_end_of_set) |=> (rsp_sorted_value >= $past(rsp_sorted_value)))
      else $error("results out of ascending order");

   // No item is taken while a set is being emitted.
   a_busy_while_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("results shown while accepting items");

endmodule

bind sort_values_ascending srt_checker u_srt_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for sort_values_ascending: sends sets of signed values and checks
// that each set comes back in ascending order. Depends on srt_pkg and the RTL.
module tb_top;

   localparam int CycleLimit = 100000;
   localparam srt_pkg::value_type MostNegative = 32'sh8000_0000;
   localparam srt_pkg::value_type MostPositive = 32'sh7FFF_FFFF;

   typedef struct {
      srt_pkg::value_type sorted_value;
      logic               end_of_set;
   } sorted_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   srt_pkg::value_type req_value = '0;
   logic               req_last = 1'b0;
   logic               busy;
   logic               rsp_valid;
   srt_pkg::value_type rsp_sorted_value;
   logic               rsp_end_of_set;

   // Predicted state: the values held so far, kept in ascending order.
   srt_pkg::value_type held_values[$];
   sorted_entry_type   pending_sorted[$];

   int sender_idle_pct = 0;
   int items_accepted  = 0;
   int sets_done       = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int largest_set     = 0;

   sort_values_ascending dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_set   (rsp_end_of_set)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Values beyond capacity are dropped; a last item releases the whole set.
   function automatic void absorb_item(srt_pkg::value_type v, logic is_last);
      int pos;
      sorted_entry_type entry;
      items_accepted++;
      if (held_values.size() < srt_pkg::MaxItems) begin
         pos = held_values.size();
         while (pos > 0 && held_values[pos-1] > v) pos--;
         held_values.insert(pos, v);
      end
      if (is_last) begin
         if (held_values.size() > largest_set) largest_set = held_values.size();
         foreach (held_values[k]) begin
            entry.sorted_value = held_values[k];
            entry.end_of_set   = (k == held_values.size() - 1);
            pending_sorted.push_back(entry);
         end
         held_values.delete();
         sets_done++;
      end
   endfunction

   function automatic void check_result(srt_pkg::value_type got_value, logic got_end);
      sorted_entry_type want;
      if (pending_sorted.size() == 0) begin
         error_count++;
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("tb_top: unexpected result value=%0d end=%b", got_value, got_end);
         return;
      end
      want = pending_sorted.pop_front();
      results_checked++;
      if (got_value !== want.sorted_value || got_end !== want.end_of_set) begin
         error_count++;
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("tb_top: mismatch expected value=%0d end=%b, got value=%0d end=%b",
                     want.sorted_value, want.end_of_set, got_value, got_end);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) check_result(rsp_sorted_value, rsp_end_of_set);
         if (start && busy === 1'b0) absorb_item(req_value, req_last);
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: timeout after %0d cycles", CycleLimit);
      $display("tb_top: done, errors");
      $finish;
   end

   // Random idle cycles first, with junk on the request fields, then hold the
   // item until the block takes it.
   task automatic push_item(srt_pkg::value_type v, logic is_last);
      while ($urandom_range(99) < sender_idle_pct) begin
         start     <= 1'b0;
         req_value <= $signed($urandom);
         req_last  <= 1'($urandom_range(1));
         @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      req_last  <= is_last;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(negedge clock); while (pending_sorted.size() != 0);
      @(posedge clock);
   endtask

   function automatic srt_pkg::value_type pick_value(srt_pkg::value_type prev);
      case ($urandom_range(9))
         0: return MostNegative;
         1: return MostPositive;
         2, 3: return prev;
         4, 5: return srt_pkg::value_type'($urandom_range(20)) - 10;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic send_set(int size);
      srt_pkg::value_type v;
      v = $signed($urandom);
      for (int i = 1; i <= size; i++) begin
         v = pick_value(v);
         push_item(v, i == size);
      end
   endtask

   task automatic test_directed();
      srt_pkg::value_type mixed[8];
      mixed = '{0, -1, 1, MostPositive, MostNegative, -1, 0, MostPositive};
      sender_idle_pct = 0;
      push_item(MostPositive, 1'b1);
      push_item(MostNegative, 1'b1);
      foreach (mixed[i]) push_item(mixed[i], i == 7);
      for (int i = 5; i >= 1; i--) push_item(srt_pkg::value_type'(i), i == 1);
      for (int i = 0; i < 3; i++) push_item(7, i == 2);
      wait_for_drain();
   endtask

   // A full set, then sets whose last item arrives after the store is full.
   task automatic test_capacity();
      sender_idle_pct = 10;
      send_set(srt_pkg::MaxItems);
      send_set(srt_pkg::MaxItems + 1);
      send_set(srt_pkg::MaxItems + 6);
      wait_for_drain();
   endtask

   task automatic test_random(int idle_pct, int item_goal);
      int sent;
      int size;
      sent = 0;
      sender_idle_pct = idle_pct;
      while (sent < item_goal) begin
         size = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         send_set(size);
         sent += size;
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity();
      test_random(0, 30);
      test_random(47, 30);
      test_random(10, 30);
      repeat (srt_pkg::MaxItems + 8) @(posedge clock);
      if (pending_sorted.size() != 0) begin
         error_count++;
         $display("tb_top: %0d expected results never arrived", pending_sorted.size());
      end
      $display("tb_top: %0d items in %0d sets, %0d sorted results checked, %0d mismatches",
               items_accepted, sets_done, results_checked, mismatch_count);
      $display("tb_top: largest set %0d, overflow sets and idle rates 0/10/47 percent covered",
               largest_set);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
